/* src/delta_list_timer_queue_defines.svh */
// Assertion macros shared by the timer queue checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef DELTA_LIST_TIMER_QUEUE_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tlq_pkg.sv */
// Shared types and constants for the delta-list timer queue.
// Used by every module of the block; depends on nothing.
package tlq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W        = 8;
    localparam int DELTA_W     = 24;
    localparam int PEND_W      = 5;

    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_USER_W  = 3;

    // Flag positions in the result tuser.
    localparam int USER_NOTIFY  = 0;
    localparam int USER_RESTART = 1;
    localparam int USER_DROPPED = 2;

    typedef enum logic {
        FUNC_START  = 1'b0,
        FUNC_EXPIRE = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_FIX,
        S_INSERT,
        S_POP,
        S_RESULT
    } tlq_state_t;

    typedef enum logic [1:0] {
        SOP_NOP,
        SOP_WR_DELTA,
        SOP_INSERT,
        SOP_POP
    } store_op_t;

    typedef struct packed {
        store_op_t          op;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   count;
        logic [ID_W-1:0]    id;
        logic [DELTA_W-1:0] delta;
    } store_cmd_t;

endpackage

/* src/tlq_alu.sv */
// Shared 24-bit subtractor of the timer queue: difference, borrow and
// the difference clamped at zero. Depends on tlq_pkg.
module tlq_alu
    import tlq_pkg::*;
(
    input  logic [DELTA_W-1:0] a,
    input  logic [DELTA_W-1:0] b,
    output logic [DELTA_W-1:0] diff,
    output logic               borrow,
    output logic [DELTA_W-1:0] sat
);

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign sat = borrow ? '0 : diff;

endmodule

/* src/tlq_store.sv */
// Entry storage of the timer queue: ids and relative delays, with ordered
// insert, head removal and single-delay update. Depends on tlq_pkg.
module tlq_store
    import tlq_pkg::*;
(
    input  logic               aclk,
    input  store_cmd_t         cmd,
    output logic [ID_W-1:0]    head_id,
    output logic [DELTA_W-1:0] rd_delta
);

    logic [ID_W-1:0]    ids_reg    [QUEUE_DEPTH];
    logic [DELTA_W-1:0] deltas_reg [QUEUE_DEPTH];

    assign head_id  = ids_reg[0];
    assign rd_delta = deltas_reg[cmd.idx];

    // Entries from the insert point up to the old tail move one place back;
    // a removal moves every entry one place forward.
    always_ff @(posedge aclk) begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            unique case (cmd.op)
                SOP_WR_DELTA: begin
                    if (IDX_W'(j) == cmd.idx) begin
                        deltas_reg[j] <= cmd.delta;
                    end
                end
                SOP_INSERT: begin
                    if (IDX_W'(j) == cmd.idx) begin
                        ids_reg[j]    <= cmd.id;
                        deltas_reg[j] <= cmd.delta;
                    end else if (j > 0 && IDX_W'(j) > cmd.idx && CNT_W'(j) <= cmd.count) begin
                        ids_reg[j]    <= ids_reg[j-1];
                        deltas_reg[j] <= deltas_reg[j-1];
                    end
                end
                SOP_POP: begin
                    if (j < QUEUE_DEPTH - 1) begin
                        ids_reg[j]    <= ids_reg[j+1];
                        deltas_reg[j] <= deltas_reg[j+1];
                    end
                end
                SOP_NOP: begin
                end
            endcase
        end
    end

endmodule

/* src/delta_list_timer_queue.sv */
// Start request on a non-empty list: head step, walk up to the new timer's place, fix of the
// entry that it goes in front of (none at the tail), insert and result; on an empty list only
// insert and result. The walk takes one entry per cycle through the shared subtractor. Expire
// event: pop and result; dropped request: result only. A result still waiting in the output
// register adds its wait. Input is next taken at the earliest the cycle after the result loads.
// Reset (aresetn low, synchronous) empties the queue and clears the output valid.
module delta_list_timer_queue
    import tlq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // dest_id[7:0], duration_ms[31:8], elapsed_ms[55:32]
    input  logic [0:0]            s_tuser,   // func[0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // notify_id[7:0], restart_ms[31:8],
                                             // pending_count[36:32], zero[39:37]
    output logic [OUT_USER_W-1:0] m_tuser    // notify_valid[0], restart_valid[1],
                                             // dropped_full[2]
);

    tlq_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   walk_reg, walk_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [DELTA_W-1:0] rem_reg, rem_next;
    logic [DELTA_W-1:0] elapsed_reg, elapsed_next;
    logic [DELTA_W-1:0] m_reg, m_next;

    logic               res_notify_reg, res_notify_next;
    logic [ID_W-1:0]    res_notify_id_reg, res_notify_id_next;
    logic               res_restart_reg, res_restart_next;
    logic [DELTA_W-1:0] res_restart_ms_reg, res_restart_ms_next;
    logic               res_dropped_reg, res_dropped_next;
    logic [PEND_W-1:0]  res_pending_reg, res_pending_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [OUT_USER_W-1:0] m_tuser_reg, m_tuser_next;

    logic [DELTA_W-1:0] alu_a, alu_b, alu_diff, alu_sat;
    logic               alu_borrow;
    logic [DELTA_W-1:0] walk_m;
    logic [CNT_W-1:0]   walk_inc;

    store_cmd_t         cmd;
    logic [ID_W-1:0]    head_id;
    logic [DELTA_W-1:0] rd_delta;

    tlq_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow),
        .sat    (alu_sat)
    );

    tlq_store u_store (
        .aclk     (aclk),
        .cmd      (cmd),
        .head_id  (head_id),
        .rd_delta (rd_delta)
    );

    // The head's remaining time was computed ahead of the walk; later entries
    // are used as stored.
    assign walk_m   = (walk_reg == '0) ? m_reg : rd_delta;
    assign walk_inc = walk_reg + CNT_W'(1);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg           <= walk_next;
        id_reg             <= id_next;
        rem_reg            <= rem_next;
        elapsed_reg        <= elapsed_next;
        m_reg              <= m_next;
        res_notify_reg     <= res_notify_next;
        res_notify_id_reg  <= res_notify_id_next;
        res_restart_reg    <= res_restart_next;
        res_restart_ms_reg <= res_restart_ms_next;
        res_dropped_reg    <= res_dropped_next;
        res_pending_reg    <= res_pending_next;
        m_tdata_reg        <= m_tdata_next;
        m_tuser_reg        <= m_tuser_next;
    end

    always_comb begin
        state_next          = state_reg;
        count_next          = count_reg;
        walk_next           = walk_reg;
        id_next             = id_reg;
        rem_next            = rem_reg;
        elapsed_next        = elapsed_reg;
        m_next              = m_reg;
        res_notify_next     = res_notify_reg;
        res_notify_id_next  = res_notify_id_reg;
        res_restart_next    = res_restart_reg;
        res_restart_ms_next = res_restart_ms_reg;
        res_dropped_next    = res_dropped_reg;
        res_pending_next    = res_pending_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        m_tdata_next        = m_tdata_reg;
        m_tuser_next        = m_tuser_reg;
        alu_a               = '0;
        alu_b               = '0;
        cmd.op              = SOP_NOP;
        cmd.idx             = walk_reg[IDX_W-1:0];
        cmd.count           = count_reg;
        cmd.id              = id_reg;
        cmd.delta           = rem_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    id_next             = s_tdata[ID_W-1:0];
                    rem_next            = s_tdata[ID_W +: DELTA_W];
                    elapsed_next        = s_tdata[ID_W + DELTA_W +: DELTA_W];
                    walk_next           = '0;
                    res_notify_next     = 1'b0;
                    res_notify_id_next  = '0;
                    res_restart_next    = 1'b0;
                    res_restart_ms_next = '0;
                    res_dropped_next    = 1'b0;
                    res_pending_next    = PEND_W'(count_reg);
                    if (func_t'(s_tuser[0]) == FUNC_EXPIRE) begin
                        state_next = S_POP;
                    end else if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                        res_dropped_next = 1'b1;
                        state_next       = S_RESULT;
                    end else if (count_reg == '0) begin
                        state_next = S_INSERT;
                    end else begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                // Time left on the running hardware timer, clamped at zero.
                cmd.idx    = '0;
                alu_a      = rd_delta;
                alu_b      = elapsed_reg;
                m_next     = alu_sat;
                state_next = S_WALK;
            end
            S_WALK: begin
                alu_a  = rem_reg;
                alu_b  = walk_m;
                m_next = walk_m;
                if (alu_borrow) begin
                    state_next = S_FIX;
                end else begin
                    rem_next  = alu_diff;
                    walk_next = walk_inc;
                    if (walk_inc == count_reg) begin
                        state_next = S_INSERT;
                    end
                end
            end
            S_FIX: begin
                // The entry that the new timer goes in front of keeps only the
                // time beyond the new timer.
                alu_a      = m_reg;
                alu_b      = rem_reg;
                cmd.op     = SOP_WR_DELTA;
                cmd.delta  = alu_diff;
                state_next = S_INSERT;
            end
            S_INSERT: begin
                cmd.op           = SOP_INSERT;
                count_next       = count_reg + CNT_W'(1);
                res_pending_next = PEND_W'(count_reg + CNT_W'(1));
                if (walk_reg == '0) begin
                    res_restart_next    = 1'b1;
                    res_restart_ms_next = rem_reg;
                end
                state_next = S_RESULT;
            end
            S_POP: begin
                cmd.idx = IDX_W'(1);
                if (count_reg != '0) begin
                    cmd.op             = SOP_POP;
                    count_next         = count_reg - CNT_W'(1);
                    res_notify_next    = 1'b1;
                    res_notify_id_next = head_id;
                    res_pending_next   = PEND_W'(count_reg - CNT_W'(1));
                    if (count_reg > CNT_W'(1)) begin
                        res_restart_next    = 1'b1;
                        res_restart_ms_next = rd_delta;
                    end
                end
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_DATA_W'({res_pending_reg, res_restart_ms_reg,
                                                 res_notify_id_reg});
                    m_tuser_next  = {res_dropped_reg, res_restart_reg, res_notify_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/tlq_checker.sv */
// Port-level checks of the timer queue, bound to the top level.
// Depends on tlq_pkg and delta_list_timer_queue_defines.svh.
`include "delta_list_timer_queue_defines.svh"

module tlq_checker
    import tlq_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [0:0]            s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser
);

    // A dropped request changes nothing, so it reports a full queue and no event.
    `TLQ_ASSERT_SAME(a_drop_full, aclk, aresetn, m_tvalid && m_tuser[USER_DROPPED], m_tdata[ID_W + DELTA_W +: PEND_W] == PEND_W'(QUEUE_DEPTH) && !m_tuser[USER_NOTIFY] && !m_tuser[USER_RESTART], "dropped request without full queue or with event")

    `TLQ_ASSERT_SAME(a_pend_range, aclk, aresetn, m_tvalid, m_tdata[ID_W + DELTA_W +: PEND_W] <= PEND_W'(QUEUE_DEPTH), "pending count beyond queue depth")

    `TLQ_ASSERT_SAME(a_zero_fields, aclk, aresetn, m_tvalid, (m_tuser[USER_NOTIFY] || m_tdata[ID_W-1:0] == '0) && (m_tuser[USER_RESTART] || m_tdata[ID_W +: DELTA_W] == '0), "result field set without its flag")

    // Work on an item does not end in the state that takes it, so the input closes after a transfer.
    `TLQ_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while an item is in work")

endmodule

bind delta_list_timer_queue tlq_checker u_tlq_checker (.*);
